FILE: hw/rtl/vswa_pkg.sv
package vswa_pkg;

    // voxel memory geometry
    localparam int MEM_DEPTH = 32768;
    localparam int ADDR_W    = 15;
    localparam int WORD_W    = 64;

    // cell coordinate and linear index widths (grid sizes up to 512)
    localparam int CELL_W = 9;
    localparam int IDX_W  = 27;

    // divider widths: signed numerator, magnitude, divisor magnitude, step count
    localparam int NUM_W = 49;
    localparam int MAG_W = 48;
    localparam int DEN_W = 32;
    localparam int CNT_W = 6;

    // stream payload widths
    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 88;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_Y     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_Z     = 3'd6;

    localparam logic [30:0] CELL_LENGTH_RESET = 31'd65536;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_WZERO = 2'd2;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_W,
        S_QLOAD,
        S_QDIV,
        S_QFIN,
        S_QCHK,
        S_CDIV,
        S_CFIN,
        S_CCHK,
        S_INDEX,
        S_IDXCHK,
        S_MEM_OUT,
        S_ERR_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       clr_step;
        logic       load;
        logic [1:0] axis;
        logic       div_load;
        logic       div_cell;
        logic       div_step;
        logic       div_fin;
        logic       cell_save;
        logic       idx_calc;
        logic       mem_rd;
        logic       out_ok;
        logic       set_err;
        logic [1:0] err_code;
        logic       out_err;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_done;
        logic w_zero;
        logic div_last;
        logic q_ok;
        logic len_nz;
        logic c_ok;
        logic idx_ok;
        logic out_free;
    } t_sts;

endpackage

FILE: hw/rtl/voxel_store_world_addressed.sv
// flow: a result is returned once the checks and the memory read are done; a w of zero
// or a location out of range finishes earlier, after the failing check
// requests: one at a time; a full request makes six passes of the single bit-serial divider
// (three by w, three by cell length), and the next is taken once the result is registered
// reset: synchronous active low; configuration returns to defaults and a clear
// sweep zeroes all 32768 words of the voxel memory before the first request is taken
module voxel_store_world_addressed import vswa_pkg::*; #(
    parameter int SIZE_X = 32,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // loc_x, loc_y, loc_z, loc_w, write_mask, sdf_in, weight_in, color_in, zero pad
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // operation
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, voxel_index, sdf_out, weight_out, color_out, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]           i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    vswa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // divider, checks, memory and output register
    vswa_datapath #(
        .SIZE_X (SIZE_X),
        .SIZE_Y (SIZE_Y),
        .SIZE_Z (SIZE_Z)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request accepted while another is in flight");

    // error results carry zero fields
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[1:0] != ST_OK) |-> (m_axis_tdata[80:2] == '0))
        else $error("error result with nonzero fields");

    // no undefined status code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_OK || m_axis_tdata[1:0] == ST_RANGE
                           || m_axis_tdata[1:0] == ST_WZERO))
        else $error("undefined status code");

endmodule

FILE: hw/rtl/vswa_ram.sv
module vswa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/vswa_ctrl.sv
module vswa_ctrl import vswa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    // state and axis registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_axis  <= AXIS_X;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr_step = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_axis     = AXIS_X;
                    n_state    = S_CHK_W;
                end
            end
            S_CHK_W: begin
                if (i_sts.w_zero) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_WZERO;
                    n_state        = S_ERR_OUT;
                end else begin
                    n_state = S_QLOAD;
                end
            end
            S_QLOAD: begin
                o_cmd.div_load = 1'b1;
                n_state        = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_QFIN;
                end
            end
            S_QFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_QCHK;
            end
            S_QCHK: begin
                if (!(i_sts.q_ok && i_sts.len_nz)) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_RANGE;
                    n_state        = S_ERR_OUT;
                end else begin
                    o_cmd.div_load = 1'b1;
                    o_cmd.div_cell = 1'b1;
                    n_state        = S_CDIV;
                end
            end
            S_CDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_CFIN;
                end
            end
            S_CFIN: begin
                o_cmd.div_fin = 1'b1;
                n_state       = S_CCHK;
            end
            S_CCHK: begin
                if (!i_sts.c_ok) begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_RANGE;
                    n_state        = S_ERR_OUT;
                end else begin
                    o_cmd.cell_save = 1'b1;
                    if (r_axis == AXIS_Z) begin
                        n_state = S_INDEX;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = S_QLOAD;
                    end
                end
            end
            S_INDEX: begin
                o_cmd.idx_calc = 1'b1;
                n_state        = S_IDXCHK;
            end
            S_IDXCHK: begin
                if (i_sts.idx_ok) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state      = S_MEM_OUT;
                end else begin
                    o_cmd.set_err  = 1'b1;
                    o_cmd.err_code = ST_RANGE;
                    n_state        = S_ERR_OUT;
                end
            end
            S_MEM_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ok = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ERR_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_err = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/vswa_datapath.sv
module vswa_datapath import vswa_pkg::*; #(
    parameter int SIZE_X = 32,
    parameter int SIZE_Y = 32,
    parameter int SIZE_Z = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_user,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // configuration registers
    logic signed [31:0] r_org_x, r_org_y, r_org_z;
    logic [30:0]        r_len;
    logic [63:0]        r_rng_x, r_rng_y, r_rng_z;

    // captured request
    logic               r_op;
    logic signed [31:0] r_loc_x, r_loc_y, r_loc_z, r_w;
    logic [2:0]         r_mask;
    logic [15:0]        r_sdf, r_wt;
    logic [31:0]        r_col;

    // divider
    logic [MAG_W-1:0]        r_dvd;
    logic [DEN_W-1:0]        r_rem, r_dvs;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [NUM_W-1:0] r_q;

    // cells, index, clear sweep, output
    logic [CELL_W-1:0] r_cx, r_cy, r_cz;
    logic [IDX_W-1:0]  r_idx;
    logic [ADDR_W-1:0] r_clr;
    logic              r_clr_done;
    logic [1:0]        r_err;
    logic              r_ov;
    logic [1:0]        r_st;
    logic [14:0]       r_oidx;
    logic [15:0]       r_osdf, r_owt;
    logic [31:0]       r_ocol;

    logic signed [31:0]      loc_sel, org_sel;
    logic [63:0]             rng_sel;
    logic signed [NUM_W-1:0] size_sel, lo_sel, hi_sel;
    logic signed [NUM_W-1:0] num_sel, num_abs;
    logic signed [DEN_W:0]   den_sel, den_abs;
    logic [DEN_W:0]          rem_sh, rem_sub;
    logic                    rem_ge;
    logic [NUM_W-1:0]        q_mag;
    logic [WORD_W-1:0]       rd_word, merged;
    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_len   <= CELL_LENGTH_RESET;
            r_rng_x <= '0;
            r_rng_y <= '0;
            r_rng_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_ORIGIN_X:    r_org_x <= i_cfg_data[31:0];
                REG_ORIGIN_Y:    r_org_y <= i_cfg_data[31:0];
                REG_ORIGIN_Z:    r_org_z <= i_cfg_data[31:0];
                REG_CELL_LENGTH: r_len   <= i_cfg_data[30:0];
                REG_RANGE_X:     r_rng_x <= i_cfg_data;
                REG_RANGE_Y:     r_rng_y <= i_cfg_data;
                REG_RANGE_Z:     r_rng_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_in_user;
            r_loc_x <= i_in_data[31:0];
            r_loc_y <= i_in_data[63:32];
            r_loc_z <= i_in_data[95:64];
            r_w     <= i_in_data[127:96];
            r_mask  <= i_in_data[130:128];
            r_sdf   <= i_in_data[146:131];
            r_wt    <= i_in_data[162:147];
            r_col   <= i_in_data[194:163];
        end
    end

    // per-axis selection
    always_comb begin
        unique case (i_cmd.axis)
            AXIS_X: begin
                loc_sel  = r_loc_x;
                org_sel  = r_org_x;
                rng_sel  = r_rng_x;
                size_sel = NUM_W'(SIZE_X);
            end
            AXIS_Y: begin
                loc_sel  = r_loc_y;
                org_sel  = r_org_y;
                rng_sel  = r_rng_y;
                size_sel = NUM_W'(SIZE_Y);
            end
            default: begin
                loc_sel  = r_loc_z;
                org_sel  = r_org_z;
                rng_sel  = r_rng_z;
                size_sel = NUM_W'(SIZE_Z);
            end
        endcase
        lo_sel = NUM_W'($signed(rng_sel[31:0]));
        hi_sel = NUM_W'($signed(rng_sel[63:32]));
    end

    // divider operands: location over w, or offset over cell length
    always_comb begin
        if (i_cmd.div_cell) begin
            num_sel = NUM_W'($signed(r_q[31:0])) - NUM_W'(org_sel);
            den_sel = {2'b00, r_len};
        end else begin
            num_sel = NUM_W'($signed({loc_sel, 16'h0000}));
            den_sel = (DEN_W+1)'(r_w);
        end
        num_abs = num_sel[NUM_W-1] ? -num_sel : num_sel;
        den_abs = den_sel[DEN_W] ? -den_sel : den_sel;
    end

    // restoring division step
    assign rem_sh  = {r_rem, r_dvd[MAG_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_dvs};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign q_mag   = {1'b0, r_dvd};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_dvd <= num_abs[MAG_W-1:0];
            r_dvs <= den_abs[DEN_W-1:0];
            r_rem <= '0;
            r_neg <= num_sel[NUM_W-1] ^ den_sel[DEN_W];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[MAG_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_cnt <= r_cnt + CNT_W'(1);
        end
        // signed floor of the magnitude quotient
        if (i_cmd.div_fin) begin
            if (r_neg) begin
                r_q <= -$signed(q_mag) - NUM_W'(r_rem != '0);
            end else begin
                r_q <= $signed(q_mag);
            end
        end
    end

    // cell coordinates and linear index
    always_ff @(posedge i_clk) begin
        if (i_cmd.cell_save) begin
            unique case (i_cmd.axis)
                AXIS_X:  r_cx <= r_q[CELL_W-1:0];
                AXIS_Y:  r_cy <= r_q[CELL_W-1:0];
                default: r_cz <= r_q[CELL_W-1:0];
            endcase
        end
        if (i_cmd.idx_calc) begin
            r_idx <= IDX_W'(r_cx) + IDX_W'(r_cy) * IDX_W'(SIZE_X)
                   + IDX_W'(r_cz) * IDX_W'(SIZE_X * SIZE_Y);
        end
        if (i_cmd.set_err) begin
            r_err <= i_cmd.err_code;
        end
    end

    // clear sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_clr_done <= 1'b0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + ADDR_W'(1);
            if (r_clr == '1) begin
                r_clr_done <= 1'b1;
            end
        end
    end

    // masked update of the read voxel
    always_comb begin
        merged = rd_word;
        if (r_op) begin
            if (r_mask[0]) merged[15:0]  = r_sdf;
            if (r_mask[1]) merged[31:16] = r_wt;
            if (r_mask[2]) merged[63:32] = r_col;
        end
    end

    assign ram_we    = i_cmd.clr_step || (i_cmd.out_ok && r_op);
    assign ram_waddr = i_cmd.clr_step ? r_clr : r_idx[ADDR_W-1:0];
    assign ram_wdata = i_cmd.clr_step ? '0 : merged;

    vswa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.mem_rd),
        .i_raddr (r_idx[ADDR_W-1:0]),
        .o_rdata (rd_word)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_ok || i_cmd.out_err) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ok) begin
            r_st   <= ST_OK;
            r_oidx <= r_idx[14:0];
            r_osdf <= merged[15:0];
            r_owt  <= merged[31:16];
            r_ocol <= merged[63:32];
        end else if (i_cmd.out_err) begin
            r_st   <= r_err;
            r_oidx <= '0;
            r_osdf <= '0;
            r_owt  <= '0;
            r_ocol <= '0;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = {7'b0, r_ocol, r_owt, r_osdf, r_oidx, r_st};

    // status back to the controller
    always_comb begin
        o_sts.clr_done = r_clr_done;
        o_sts.w_zero   = (r_w == '0);
        o_sts.div_last = (r_cnt == CNT_W'(MAG_W - 1));
        o_sts.q_ok     = (r_q >= lo_sel) && (r_q <= hi_sel);
        o_sts.len_nz   = (r_len != '0);
        o_sts.c_ok     = !r_q[NUM_W-1] && (r_q < size_sel);
        o_sts.idx_ok   = (r_idx < IDX_W'(MEM_DEPTH));
        o_sts.out_free = !r_ov || i_out_ready;
    end

endmodule
